// ===== hdl/gnl_pkg.sv =====
// Shared types and constants for the grid neighbour lister.
`timescale 1ns / 1ps
`default_nettype none

package gnl_pkg;

    localparam int NODE_W = 13;
    localparam int DIM_W = 7;
    localparam int SLOT_W = 6;
    localparam int CNT_W = 7;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 7;

    localparam int DEF_MAX_ROWS = 64;
    localparam int DEF_MAX_COLS = 64;
    localparam int RESULT_CAP = 64;

    localparam int LIST_LEN = 4;
    localparam int LIST_IDX_W = 2;

    localparam int DIV_STEP = 4;
    localparam int DIV_CYCLES = 4;
    localparam int DIV_CNT_W = 2;
    localparam int DIV_PAD = DIV_STEP * DIV_CYCLES;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRID_MODE = 2'd0,
        CFG_ROW_COUNT = 2'd1,
        CFG_COL_COUNT = 2'd2
    } t_cfg_index;

    typedef enum logic [1:0] {
        FS_IDLE,
        FS_DIV,
        FS_PUSH
    } t_front_state;

    typedef enum logic [1:0] {
        JK_ERROR,
        JK_LIST,
        JK_ROW
    } t_job_kind;

    typedef struct packed {
        logic             spherical;
        logic [DIM_W-1:0] rows;
        logic [DIM_W-1:0] cols;
    } t_dims;

    typedef struct packed {
        t_job_kind                         kind;
        logic [CNT_W-1:0]                  count;
        logic [NODE_W-1:0]                 base;
        logic [LIST_LEN-1:0][NODE_W-1:0]   idx;
    } t_job;

    typedef struct packed {
        logic full;
        logic valid;
    } t_queue_status;

endpackage

`default_nettype wire

// ===== hdl/grid_neighbour_lister_top.sv =====
// Top level of the grid neighbour lister: configuration registers and the three stages.
//
// The front end accepts a node index, runs the four-bit-per-step divider that splits
// the index into row and column, then classifies the job and queues it; it takes no
// new index until that job is queued. The sequencer loads each job from the queue
// and then delivers one neighbour beat per cycle while the output is not stalled, so
// a grid node yields up to four beats and a pole as many beats as there are columns.
// An index outside the configured grid yields a single beat with the error flag set.
`timescale 1ns / 1ps
`default_nettype none

module grid_neighbour_lister_top #(
    parameter int MAX_ROWS = gnl_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = gnl_pkg::DEF_MAX_COLS
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [gnl_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [gnl_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic [gnl_pkg::NODE_W-1:0]        i_node_index,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic [gnl_pkg::NODE_W-1:0]             o_neighbour_index,
    output logic [gnl_pkg::SLOT_W-1:0]             o_neighbour_slot,
    output logic [gnl_pkg::CNT_W-1:0]              o_neighbour_count,
    output logic                                   o_last_item,
    output logic                                   o_index_error
);
    import gnl_pkg::*;

    localparam int DimMax = (1 << DIM_W) - 1;
    localparam int RowCap = (MAX_ROWS < DimMax) ? MAX_ROWS : DimMax;
    localparam int ColLim = (MAX_COLS < RESULT_CAP) ? MAX_COLS : RESULT_CAP;
    localparam int ColCap = (ColLim < DimMax) ? ColLim : DimMax;

    logic r_grid_mode;
    logic [DIM_W-1:0] r_row_count;
    logic [DIM_W-1:0] r_col_count;

    t_dims w_dims;
    t_job w_front_job;
    t_job w_queue_job;
    t_queue_status w_q_status;
    logic w_push;
    logic w_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_mode <= 1'b0;
            r_row_count <= DIM_W'(2);
            r_col_count <= DIM_W'(2);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_GRID_MODE: r_grid_mode <= i_cfg_data[0];
                CFG_ROW_COUNT: r_row_count <= i_cfg_data;
                CFG_COL_COUNT: r_col_count <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        w_dims.spherical = r_grid_mode;
        if (r_row_count < DIM_W'(2)) begin
            w_dims.rows = DIM_W'(2);
        end else if (r_row_count > DIM_W'(RowCap)) begin
            w_dims.rows = DIM_W'(RowCap);
        end else begin
            w_dims.rows = r_row_count;
        end
        if (r_col_count < DIM_W'(2)) begin
            w_dims.cols = DIM_W'(2);
        end else if (r_col_count > DIM_W'(ColCap)) begin
            w_dims.cols = DIM_W'(ColCap);
        end else begin
            w_dims.cols = r_col_count;
        end
    end

    gnl_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_node_index (i_node_index),
        .i_dims       (w_dims),
        .i_q_status   (w_q_status),
        .o_push       (w_push),
        .o_job        (w_front_job)
    );

    gnl_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_job    (w_front_job),
        .i_pop    (w_pop),
        .o_job    (w_queue_job),
        .o_status (w_q_status)
    );

    gnl_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_job             (w_queue_job),
        .i_q_status        (w_q_status),
        .o_pop             (w_pop),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_neighbour_index (o_neighbour_index),
        .o_neighbour_slot  (o_neighbour_slot),
        .o_neighbour_count (o_neighbour_count),
        .o_last_item       (o_last_item),
        .o_index_error     (o_index_error)
    );

    // The front end never pushes into a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_q_status.full)
        else $error("job queue overflow");

    // An error beat stands alone and reports no neighbours.
    a_error_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_index_error) |->
            (o_last_item && o_neighbour_count == '0 && o_neighbour_index == '0))
        else $error("malformed error beat");

    // A neighbour beat has its slot inside the count, and the last one closes it.
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_index_error) |->
            (CNT_W'(o_neighbour_slot) < o_neighbour_count))
        else $error("slot beyond neighbour count");

    a_last_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_index_error && o_last_item) |->
            (CNT_W'(o_neighbour_slot) + CNT_W'(1) == o_neighbour_count))
        else $error("last beat at wrong slot");

endmodule

`default_nettype wire

// ===== hdl/gnl_front.sv =====
// Front end: accepts a node index, divides it by the column count and builds a job.
`timescale 1ns / 1ps
`default_nettype none

module gnl_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [gnl_pkg::NODE_W-1:0]    i_node_index,
    input  wire gnl_pkg::t_dims                i_dims,
    input  wire gnl_pkg::t_queue_status        i_q_status,
    output logic                               o_push,
    output gnl_pkg::t_job                      o_job
);
    import gnl_pkg::*;

    t_front_state r_state, n_state;
    logic [DIV_CNT_W-1:0] r_div_cnt;
    logic [DIV_PAD-1:0] r_dividend;
    logic [DIM_W:0] r_rem;
    logic [NODE_W-1:0] r_quot;
    logic [NODE_W-1:0] r_node;
    logic [NODE_W-1:0] r_grid_nodes;
    t_dims r_dims;

    logic w_accept;
    logic w_div_last;

    logic [DIM_W:0] v_rem;
    logic [DIV_PAD-1:0] v_dvd;
    logic [NODE_W-1:0] v_quot;

    always_comb begin
        v_rem = r_rem;
        v_dvd = r_dividend;
        v_quot = r_quot;
        for (int s = 0; s < DIV_STEP; s++) begin
            v_rem = {v_rem[DIM_W-1:0], v_dvd[DIV_PAD-1]};
            v_dvd = {v_dvd[DIV_PAD-2:0], 1'b0};
            if (v_rem >= {1'b0, r_dims.cols}) begin
                v_rem = v_rem - {1'b0, r_dims.cols};
                v_quot = {v_quot[NODE_W-2:0], 1'b1};
            end else begin
                v_quot = {v_quot[NODE_W-2:0], 1'b0};
            end
        end
    end

    assign w_div_last = (r_div_cnt == DIV_CNT_W'(DIV_CYCLES - 1));

    always_comb begin
        n_state = r_state;
        case (r_state)
            FS_IDLE: begin
                if (i_in_valid) n_state = FS_DIV;
            end
            FS_DIV: begin
                if (w_div_last) n_state = FS_PUSH;
            end
            FS_PUSH: begin
                if (!i_q_status.full) n_state = FS_IDLE;
            end
            default: n_state = FS_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall = 1'b1;
        w_accept = 1'b0;
        o_push = 1'b0;
        case (r_state)
            FS_IDLE: begin
                o_in_stall = 1'b0;
                w_accept = i_in_valid;
            end
            FS_DIV: begin
                o_in_stall = 1'b1;
            end
            FS_PUSH: begin
                o_push = !i_q_status.full;
            end
            default: o_in_stall = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FS_IDLE;
            r_div_cnt <= '0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_div_cnt <= '0;
            end else if (r_state == FS_DIV) begin
                r_div_cnt <= r_div_cnt + DIV_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_node <= i_node_index;
            r_dims <= i_dims;
            r_dividend <= DIV_PAD'(i_node_index);
            r_rem <= '0;
            r_quot <= '0;
        end else if (r_state == FS_DIV) begin
            r_dividend <= v_dvd;
            r_rem <= v_rem;
            r_quot <= v_quot;
            r_grid_nodes <= NODE_W'(r_dims.rows * r_dims.cols);
        end
    end

    logic [NODE_W-1:0] w_cols;
    logic [NODE_W-1:0] w_total;
    logic [NODE_W-1:0] w_north;
    logic [NODE_W-1:0] w_south;
    logic [NODE_W-1:0] w_rem;
    logic w_top, w_bot, w_lft, w_rgt;
    logic [LIST_LEN-1:0][NODE_W-1:0] w_cand;
    logic [LIST_LEN-1:0] w_present;
    logic [LIST_IDX_W:0] v_cur;

    assign w_cols = NODE_W'(r_dims.cols);
    assign w_total = r_grid_nodes + (r_dims.spherical ? NODE_W'(2) : NODE_W'(0));
    assign w_north = w_total - NODE_W'(1);
    assign w_south = w_total - NODE_W'(2);
    assign w_rem = NODE_W'(r_rem[DIM_W-1:0]);
    assign w_top = (r_quot == '0);
    assign w_bot = (r_quot == NODE_W'(r_dims.rows) - NODE_W'(1));
    assign w_lft = (r_rem[DIM_W-1:0] == '0);
    assign w_rgt = (r_rem[DIM_W-1:0] == r_dims.cols - DIM_W'(1));

    // Candidate order is right, top, left, bottom; missing ones drop out.
    always_comb begin
        w_cand[0] = (r_dims.spherical && w_rgt) ? r_node - w_rem : r_node + NODE_W'(1);
        w_cand[1] = (r_dims.spherical && w_top) ? w_north : r_node - w_cols;
        w_cand[2] = (r_dims.spherical && w_lft) ? r_node + w_cols - NODE_W'(1)
                                                : r_node - NODE_W'(1);
        w_cand[3] = (r_dims.spherical && w_bot) ? w_south : r_node + w_cols;
        w_present = r_dims.spherical ? '1 : {!w_bot, !w_lft, !w_top, !w_rgt};
    end

    always_comb begin
        o_job = '0;
        v_cur = '0;
        if (r_node >= w_total) begin
            o_job.kind = JK_ERROR;
        end else if (r_dims.spherical && r_node == w_north) begin
            o_job.kind = JK_ROW;
            o_job.count = CNT_W'(r_dims.cols);
            o_job.base = '0;
        end else if (r_dims.spherical && r_node == w_south) begin
            o_job.kind = JK_ROW;
            o_job.count = CNT_W'(r_dims.cols);
            o_job.base = r_grid_nodes - w_cols;
        end else begin
            o_job.kind = JK_LIST;
            for (int k = 0; k < LIST_LEN; k++) begin
                if (w_present[k]) begin
                    o_job.idx[v_cur[LIST_IDX_W-1:0]] = w_cand[k];
                    v_cur = v_cur + (LIST_IDX_W + 1)'(1);
                end
            end
            o_job.count = CNT_W'(v_cur);
        end
    end

endmodule

`default_nettype wire

// ===== hdl/gnl_queue.sv =====
// Short job queue between the front end and the result sequencer.
`timescale 1ns / 1ps
`default_nettype none

module gnl_queue (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_push,
    input  wire gnl_pkg::t_job          i_job,
    input  wire logic                   i_pop,
    output gnl_pkg::t_job               o_job,
    output gnl_pkg::t_queue_status      o_status
);
    import gnl_pkg::*;

    t_job r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0] r_count;

    assign o_status.full = (r_count == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign o_status.valid = (r_count != '0);
    assign o_job = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            if (i_pop) r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            if (i_push && !i_pop) begin
                r_count <= r_count + (QPTR_W + 1)'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - (QPTR_W + 1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_job;
    end

endmodule

`default_nettype wire

// ===== hdl/gnl_back.sv =====
// Result sequencer: expands one job into neighbour beats through an output register.
`timescale 1ns / 1ps
`default_nettype none

module gnl_back (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire gnl_pkg::t_job                 i_job,
    input  wire gnl_pkg::t_queue_status        i_q_status,
    output logic                               o_pop,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [gnl_pkg::NODE_W-1:0]         o_neighbour_index,
    output logic [gnl_pkg::SLOT_W-1:0]         o_neighbour_slot,
    output logic [gnl_pkg::CNT_W-1:0]          o_neighbour_count,
    output logic                               o_last_item,
    output logic                               o_index_error
);
    import gnl_pkg::*;

    t_job r_job;
    logic r_active;
    logic [SLOT_W-1:0] r_slot;
    logic r_out_valid;

    logic w_emit;
    logic w_last;
    logic [NODE_W-1:0] w_index;

    assign o_pop = !r_active && i_q_status.valid;
    assign w_emit = r_active && (!r_out_valid || !i_out_stall);
    assign w_last = (r_job.kind == JK_ERROR)
                 || ((CNT_W'(r_slot) + CNT_W'(1)) == r_job.count);

    always_comb begin
        case (r_job.kind)
            JK_LIST: w_index = r_job.idx[r_slot[LIST_IDX_W-1:0]];
            JK_ROW:  w_index = r_job.base + NODE_W'(r_slot);
            default: w_index = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_active <= 1'b1;
            end else if (w_emit && w_last) begin
                r_active <= 1'b0;
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
            r_slot <= '0;
        end else if (w_emit) begin
            r_slot <= r_slot + SLOT_W'(1);
        end
        if (w_emit) begin
            o_neighbour_index <= w_index;
            o_neighbour_slot <= r_slot;
            o_neighbour_count <= (r_job.kind == JK_ERROR) ? '0 : r_job.count;
            o_last_item <= w_last;
            o_index_error <= (r_job.kind == JK_ERROR);
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the grid neighbour lister with directed and random node queries.
`timescale 1ns / 1ps

module tb;
    import gnl_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 12;
    localparam int MAX_IDLE = 16;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS = 13;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic [NODE_W-1:0] index;
        logic [SLOT_W-1:0] slot;
        logic [CNT_W-1:0]  count;
        logic              last;
        logic              error;
    } t_beat;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic [NODE_W-1:0]     i_node_index = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [NODE_W-1:0]     o_neighbour_index;
    logic [SLOT_W-1:0]     o_neighbour_slot;
    logic [CNT_W-1:0]      o_neighbour_count;
    logic                  o_last_item;
    logic                  o_index_error;

    logic                  model_mode;
    logic [DIM_W-1:0]      model_rows;
    logic [DIM_W-1:0]      model_cols;

    t_beat                 expected_beats[$];
    t_beat                 seen_beat;
    t_beat                 want_beat;
    bit                    idle_on = 1'b1;
    int                    fail_count = 0;
    int                    beats_checked = 0;
    int                    nodes_sent = 0;
    int                    settings_applied = 0;
    int                    stall_cycles;
    int                    idle_cycles;

    grid_neighbour_lister_top dut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic int unsigned eff_rows();
        if (model_rows < 2) return 2;
        if (model_rows > DEF_MAX_ROWS) return DEF_MAX_ROWS;
        return 32'(model_rows);
    endfunction

    function automatic int unsigned eff_cols();
        int unsigned cap;
        cap = (DEF_MAX_COLS < RESULT_CAP) ? DEF_MAX_COLS : RESULT_CAP;
        if (model_cols < 2) return 2;
        if (model_cols > cap) return cap;
        return 32'(model_cols);
    endfunction

    function automatic int unsigned node_total();
        return eff_rows() * eff_cols() + (model_mode ? 2 : 0);
    endfunction

    function automatic void predict_neighbours(input logic [NODE_W-1:0] node);
        int unsigned r, c, total, n, row, col, k;
        bit top, bot, lft, rgt;
        int unsigned nbr[$];
        t_beat b;
        r = eff_rows();
        c = eff_cols();
        total = node_total();
        n = 32'(node);
        if (n >= total) begin
            b = '{index: '0, slot: '0, count: '0, last: 1'b1, error: 1'b1};
            expected_beats.push_back(b);
        end else begin
            row = n / c;
            col = n % c;
            if (model_mode) begin
                if (n == total - 1) begin
                    for (k = 0; k < c; k++) nbr.push_back(k);
                end else if (n == total - 2) begin
                    for (k = 0; k < c; k++) nbr.push_back((r - 1) * c + k);
                end else begin
                    nbr.push_back(row * c + ((col + 1 == c) ? 0 : col + 1));
                    nbr.push_back((row == 0) ? total - 1 : n - c);
                    nbr.push_back(row * c + ((col == 0) ? c - 1 : col - 1));
                    nbr.push_back((row == r - 1) ? total - 2 : n + c);
                end
            end else begin
                top = (row == 0);
                bot = (row == r - 1);
                lft = (col == 0);
                rgt = (col == c - 1);
                if (top && lft) begin
                    nbr.push_back(n + 1);
                    nbr.push_back(n + c);
                end else if (top && rgt) begin
                    nbr.push_back(n - 1);
                    nbr.push_back(n + c);
                end else if (bot && lft) begin
                    nbr.push_back(n + 1);
                    nbr.push_back(n - c);
                end else if (bot && rgt) begin
                    nbr.push_back(n - c);
                    nbr.push_back(n - 1);
                end else if (top) begin
                    nbr.push_back(n + 1);
                    nbr.push_back(n - 1);
                    nbr.push_back(n + c);
                end else if (lft) begin
                    nbr.push_back(n + 1);
                    nbr.push_back(n - c);
                    nbr.push_back(n + c);
                end else if (rgt) begin
                    nbr.push_back(n - c);
                    nbr.push_back(n - 1);
                    nbr.push_back(n + c);
                end else if (bot) begin
                    nbr.push_back(n + 1);
                    nbr.push_back(n - c);
                    nbr.push_back(n - 1);
                end else begin
                    nbr.push_back(n + 1);
                    nbr.push_back(n - c);
                    nbr.push_back(n - 1);
                    nbr.push_back(n + c);
                end
            end
            for (k = 0; k < nbr.size(); k++) begin
                b.index = NODE_W'(nbr[k]);
                b.slot = SLOT_W'(k);
                b.count = CNT_W'(nbr.size());
                b.last = (k + 1 == nbr.size());
                b.error = 1'b0;
                expected_beats.push_back(b);
            end
        end
    endfunction

    function automatic logic [DIM_W-1:0] rand_dim();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 6) return DIM_W'($urandom_range(2, 6));
        if (pick == 6) return DIM_W'($urandom_range(7, 64));
        if (pick == 7) return DIM_W'(64);
        if (pick == 8) return DIM_W'(2);
        return DIM_W'($urandom_range(0, 127));
    endfunction

    task automatic configure(input logic mode, input logic [DIM_W-1:0] rows,
                             input logic [DIM_W-1:0] cols);
        logic [CFG_DATA_W-1:0] mode_word;
        mode_word = CFG_DATA_W'($urandom);
        mode_word[0] = mode;
        i_cfg_we <= 1'b1;
        i_cfg_index <= CFG_GRID_MODE;
        i_cfg_data <= mode_word;
        @(posedge i_clk);
        i_cfg_index <= CFG_ROW_COUNT;
        i_cfg_data <= rows;
        @(posedge i_clk);
        i_cfg_index <= CFG_COL_COUNT;
        i_cfg_data <= cols;
        @(posedge i_clk);
        i_cfg_index <= CFG_UNUSED;
        i_cfg_data <= CFG_DATA_W'($urandom);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        model_mode = mode;
        model_rows = rows;
        model_cols = cols;
        settings_applied++;
    endtask

    task automatic send_node(input logic [NODE_W-1:0] node);
        int gap;
        gap = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        predict_neighbours(node);
        i_in_valid <= 1'b1;
        i_node_index <= node;
        do @(posedge i_clk); while (o_in_stall);
        nodes_sent++;
    endtask

    task automatic wait_for_drain();
        i_in_valid <= 1'b0;
        while (expected_beats.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic test_reset_defaults();
        send_node(NODE_W'(3));
        send_node({NODE_W{1'b1}});
        wait_for_drain();
    endtask

    task automatic test_rectilinear_classes();
        configure(1'b0, DIM_W'(4), DIM_W'(4));
        send_node(NODE_W'(0));
        send_node(NODE_W'(3));
        send_node(NODE_W'(12));
        send_node(NODE_W'(15));
        send_node(NODE_W'(1));
        send_node(NODE_W'(4));
        send_node(NODE_W'(7));
        send_node(NODE_W'(13));
        send_node(NODE_W'(5));
        send_node(NODE_W'(16));
        wait_for_drain();
    endtask

    task automatic test_spherical_cases();
        configure(1'b1, DIM_W'(3), DIM_W'(2));
        send_node(NODE_W'(0));
        send_node(NODE_W'(5));
        send_node(NODE_W'(6));
        send_node(NODE_W'(7));
        wait_for_drain();
        configure(1'b1, DIM_W'(64), DIM_W'(64));
        send_node(NODE_W'(4097));
        send_node(NODE_W'(4096));
        send_node(NODE_W'(4095));
        send_node(NODE_W'(4098));
        wait_for_drain();
    endtask

    task automatic test_dimension_clamping();
        configure(1'b0, DIM_W'(0), DIM_W'(127));
        send_node(NODE_W'(127));
        send_node(NODE_W'(128));
        wait_for_drain();
        configure(1'b1, DIM_W'(1), DIM_W'(1));
        send_node(NODE_W'(5));
        send_node(NODE_W'(6));
        wait_for_drain();
        configure(1'b0, DIM_W'(127), DIM_W'(0));
        send_node(NODE_W'(127));
        send_node(NODE_W'(128));
        wait_for_drain();
    endtask

    task automatic test_random_queries();
        int phase, item, pick;
        int unsigned total;
        logic [NODE_W-1:0] node;
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            idle_on = (phase % 3 != 0);
            configure(1'($urandom), rand_dim(), rand_dim());
            total = node_total();
            for (item = 0; item < PHASE_ITEMS; item++) begin
                pick = $urandom_range(0, 15);
                if (pick < 11) begin
                    node = NODE_W'($urandom_range(0, total - 1));
                end else if (pick < 13) begin
                    node = model_mode ? NODE_W'(total - 1 - $urandom_range(0, 1))
                                      : NODE_W'($urandom_range(0, eff_cols() - 1));
                end else if (pick == 13) begin
                    node = NODE_W'(total + $urandom_range(0, 3));
                end else begin
                    node = NODE_W'($urandom);
                end
                send_node(node);
            end
            wait_for_drain();
        end
    endtask

    initial begin
        forever begin
            @(posedge i_clk);
            if (o_out_valid && !i_out_stall) begin
                stall_cycles = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
                if (stall_cycles > 0) begin
                    i_out_stall <= 1'b1;
                    repeat (stall_cycles) @(posedge i_clk);
                    i_out_stall <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            seen_beat = {o_neighbour_index, o_neighbour_slot, o_neighbour_count,
                         o_last_item, o_index_error};
            beats_checked++;
            if (expected_beats.size() == 0) begin
                fail_count++;
                $display("%0t: unexpected beat, expected none, actual index=%0d slot=%0d",
                         $time, seen_beat.index, seen_beat.slot);
            end else begin
                want_beat = expected_beats.pop_front();
                if (seen_beat !== want_beat) begin
                    fail_count++;
                    $display("%0t: beat mismatch, expected index=%0d slot=%0d count=%0d",
                             $time, want_beat.index, want_beat.slot, want_beat.count,
                             " last=%0b error=%0b", want_beat.last, want_beat.error);
                    $display("%0t:                 actual index=%0d slot=%0d count=%0d",
                             $time, seen_beat.index, seen_beat.slot, seen_beat.count,
                             " last=%0b error=%0b", seen_beat.last, seen_beat.error);
                end
            end
        end
    end

    initial begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || i_cfg_we || (i_in_valid && !o_in_stall) ||
                (o_out_valid && !i_out_stall)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("%0t: no beat accepted for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        i_rst_n <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        model_mode = 1'b0;
        model_rows = DIM_W'(2);
        model_cols = DIM_W'(2);
        test_reset_defaults();
        test_rectilinear_classes();
        test_spherical_cases();
        test_dimension_clamping();
        test_random_queries();
        wait_for_drain();
        $display("Covered %0d node queries over %0d register settings in both grid modes.",
                 nodes_sent, settings_applied);
        $display("Checked %0d neighbour beats and found %0d failures.",
                 beats_checked, fail_count);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
